// File: rtl/scancode_set1_to_ascii_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the set-1 scancode translator
// Each check is a property clocked on the rising edge with a synchronous,
// active-low reset disabling it.
// ----------------------------------------------------------------------------
`ifndef SCANCODE_SET1_TO_ASCII_UNIT_ASSERT_SVH
`define SCANCODE_SET1_TO_ASCII_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define SCS1A_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("scs1a assertion failed");

// next-cycle implication
`define SCS1A_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("scs1a assertion failed");

`else

`define SCS1A_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define SCS1A_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// File: rtl/scs1a_pkg.sv
// ----------------------------------------------------------------------------
// scs1a_pkg
// Types, constants and key tables for the set-1 scancode translator.
// ----------------------------------------------------------------------------
`default_nettype none

package scs1a_pkg;

    // scancode framing
    localparam logic [7:0] BREAK_BIT  = 8'h80;
    localparam logic [6:0] CODE_MASK  = 7'h7F;
    localparam logic [7:0] LED_CMD    = 8'hED;
    localparam logic [7:0] CTRL_BASE  = 8'h1B;

    // modifier and lock keys
    localparam logic [6:0] KEY_ALT    = 7'h38;
    localparam logic [6:0] KEY_CTRL   = 7'h1D;
    localparam logic [6:0] KEY_LSHIFT = 7'h2A;
    localparam logic [6:0] KEY_RSHIFT = 7'h36;
    localparam logic [6:0] KEY_CAPS   = 7'h3A;
    localparam logic [6:0] KEY_NUM    = 7'h45;
    localparam logic [6:0] KEY_SCROLL = 7'h46;

    // flag bits
    localparam int MOD_ALT   = 0;
    localparam int MOD_CTRL  = 1;
    localparam int MOD_SHIFT = 2;
    localparam int LOCK_SCRL = 0;
    localparam int LOCK_NUM  = 1;
    localparam int LOCK_CAPS = 2;

    // result kind codes
    localparam logic KIND_CHAR = 1'b0;
    localparam logic KIND_LED  = 1'b1;

    // result count codes
    localparam logic [1:0] CNT_NONE = 2'd0;
    localparam logic [1:0] CNT_ONE  = 2'd1;
    localparam logic [1:0] CNT_TWO  = 2'd2;

    // translator outcome for one scancode
    typedef struct packed {
        logic [1:0] count;   // results caused by this item
        logic       kind;    // kind of first result
        logic [7:0] value;   // value of first result
        logic       last;    // last flag of first result
        logic [2:0] mods;    // modifier flags after this item
        logic [2:0] locks;   // lock flags after this item
    } t_xlat_res;

    // unshifted key table, zero for unused and out-of-range codes
    function automatic logic [7:0] plain_char(input logic [6:0] code);
        logic [7:0] c;
        case (code)
            7'd1:  c = 8'h1B;
            7'd2:  c = 8'h31;
            7'd3:  c = 8'h32;
            7'd4:  c = 8'h33;
            7'd5:  c = 8'h34;
            7'd6:  c = 8'h35;
            7'd7:  c = 8'h36;
            7'd8:  c = 8'h37;
            7'd9:  c = 8'h38;
            7'd10: c = 8'h39;
            7'd11: c = 8'h30;
            7'd12: c = 8'h2D;
            7'd13: c = 8'h3D;
            7'd14: c = 8'h08;
            7'd15: c = 8'h09;
            7'd16: c = 8'h71;
            7'd17: c = 8'h77;
            7'd18: c = 8'h65;
            7'd19: c = 8'h72;
            7'd20: c = 8'h74;
            7'd21: c = 8'h79;
            7'd22: c = 8'h75;
            7'd23: c = 8'h69;
            7'd24: c = 8'h6F;
            7'd25: c = 8'h70;
            7'd26: c = 8'h5B;
            7'd27: c = 8'h5D;
            7'd28: c = 8'h0A;
            7'd30: c = 8'h61;
            7'd31: c = 8'h73;
            7'd32: c = 8'h64;
            7'd33: c = 8'h66;
            7'd34: c = 8'h67;
            7'd35: c = 8'h68;
            7'd36: c = 8'h6A;
            7'd37: c = 8'h6B;
            7'd38: c = 8'h6C;
            7'd39: c = 8'h3B;
            7'd40: c = 8'h27;
            7'd41: c = 8'h60;
            7'd43: c = 8'h5C;
            7'd44: c = 8'h7A;
            7'd45: c = 8'h78;
            7'd46: c = 8'h63;
            7'd47: c = 8'h76;
            7'd48: c = 8'h62;
            7'd49: c = 8'h6E;
            7'd50: c = 8'h6D;
            7'd51: c = 8'h2C;
            7'd52: c = 8'h2E;
            7'd53: c = 8'h2F;
            7'd57: c = 8'h20;
            7'd59: c = 8'h80;
            7'd60: c = 8'h81;
            7'd61: c = 8'h82;
            7'd62: c = 8'h83;
            7'd63: c = 8'h84;
            7'd64: c = 8'h85;
            7'd65: c = 8'h86;
            7'd66: c = 8'h87;
            7'd67: c = 8'h88;
            7'd68: c = 8'h89;
            7'd71: c = 8'h92;
            7'd72: c = 8'h97;
            7'd73: c = 8'h94;
            7'd74: c = 8'h2D;
            7'd75: c = 8'h96;
            7'd76: c = 8'h35;
            7'd77: c = 8'h99;
            7'd78: c = 8'h2B;
            7'd79: c = 8'h93;
            7'd80: c = 8'h98;
            7'd81: c = 8'h95;
            7'd82: c = 8'h90;
            7'd83: c = 8'h91;
            7'd87: c = 8'h8A;
            7'd88: c = 8'h8B;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // shifted key table: symbol row differs, letters go upper case
    function automatic logic [7:0] shift_char(input logic [6:0] code);
        logic [7:0] p;
        logic [7:0] c;
        p = plain_char(code);
        case (code)
            7'd2:  c = 8'h21;
            7'd3:  c = 8'h40;
            7'd4:  c = 8'h23;
            7'd5:  c = 8'h24;
            7'd6:  c = 8'h25;
            7'd7:  c = 8'h5E;
            7'd8:  c = 8'h26;
            7'd9:  c = 8'h2A;
            7'd10: c = 8'h28;
            7'd11: c = 8'h29;
            7'd12: c = 8'h5F;
            7'd13: c = 8'h2B;
            7'd26: c = 8'h7B;
            7'd27: c = 8'h7D;
            7'd39: c = 8'h3A;
            7'd40: c = 8'h22;
            7'd41: c = 8'h7E;
            7'd43: c = 8'h7C;
            7'd51: c = 8'h3C;
            7'd52: c = 8'h3E;
            7'd53: c = 8'h3F;
            default: begin
                if (p >= 8'h61 && p <= 8'h7A) begin
                    c = p - 8'h20;
                end else begin
                    c = p;
                end
            end
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// File: rtl/scs1a_xlat.sv
// ----------------------------------------------------------------------------
// scs1a_xlat
// Combinational decode of one scancode against the modifier and lock flags:
// result count, first result and the flags left behind.
// ----------------------------------------------------------------------------
`default_nettype none

module scs1a_xlat (
    input  wire logic [7:0]          i_scancode,
    input  wire logic [2:0]          i_mods,
    input  wire logic [2:0]          i_locks,
    output scs1a_pkg::t_xlat_res     o_res
);

    logic [6:0] code;
    logic [2:0] mod_hit;
    logic [2:0] lock_hit;
    logic [7:0] plain_c;
    logic [7:0] shift_c;
    logic [7:0] char_c;
    logic       plain_lower;
    logic       shift_upper;
    logic       is_break;

    assign code     = i_scancode[6:0] & scs1a_pkg::CODE_MASK;
    assign is_break = (i_scancode & scs1a_pkg::BREAK_BIT) != 8'h00;
    assign plain_c  = scs1a_pkg::plain_char(code);
    assign shift_c  = scs1a_pkg::shift_char(code);
    assign plain_lower = (plain_c >= 8'h61) && (plain_c <= 8'h7A);
    assign shift_upper = (shift_c >= 8'h41) && (shift_c <= 8'h5A);

    // modifier and lock key decode
    always_comb begin
        mod_hit  = 3'b000;
        lock_hit = 3'b000;
        unique case (code)
            scs1a_pkg::KEY_ALT:    mod_hit[scs1a_pkg::MOD_ALT]    = 1'b1;
            scs1a_pkg::KEY_CTRL:   mod_hit[scs1a_pkg::MOD_CTRL]   = 1'b1;
            scs1a_pkg::KEY_LSHIFT,
            scs1a_pkg::KEY_RSHIFT: mod_hit[scs1a_pkg::MOD_SHIFT]  = 1'b1;
            scs1a_pkg::KEY_SCROLL: lock_hit[scs1a_pkg::LOCK_SCRL] = 1'b1;
            scs1a_pkg::KEY_NUM:    lock_hit[scs1a_pkg::LOCK_NUM]  = 1'b1;
            scs1a_pkg::KEY_CAPS:   lock_hit[scs1a_pkg::LOCK_CAPS] = 1'b1;
            default: ;
        endcase
    end

    // character selection: Alt, then Ctrl, then shift/caps
    always_comb begin
        if (i_mods[scs1a_pkg::MOD_ALT]) begin
            char_c = {1'b0, code};
        end else if (i_mods[scs1a_pkg::MOD_CTRL]) begin
            if (plain_lower) begin
                char_c = plain_c - 8'h60;
            end else if (plain_c >= 8'h5B && plain_c <= 8'h5F) begin
                char_c = plain_c - 8'h5B + scs1a_pkg::CTRL_BASE;
            end else begin
                char_c = 8'h00;
            end
        end else if (i_mods[scs1a_pkg::MOD_SHIFT]) begin
            char_c = (i_locks[scs1a_pkg::LOCK_CAPS] && shift_upper) ? plain_c : shift_c;
        end else begin
            char_c = (i_locks[scs1a_pkg::LOCK_CAPS] && plain_lower) ? shift_c : plain_c;
        end
    end

    // outcome and flag update
    always_comb begin
        o_res.count = scs1a_pkg::CNT_NONE;
        o_res.kind  = scs1a_pkg::KIND_CHAR;
        o_res.value = char_c;
        o_res.last  = 1'b1;
        o_res.mods  = i_mods;
        o_res.locks = i_locks;
        if (is_break) begin
            o_res.mods = i_mods & ~mod_hit;
        end else if (mod_hit != 3'b000) begin
            o_res.mods = i_mods | mod_hit;
        end else if (lock_hit != 3'b000) begin
            o_res.locks = i_locks ^ lock_hit;
            o_res.count = scs1a_pkg::CNT_TWO;
            o_res.kind  = scs1a_pkg::KIND_LED;
            o_res.value = scs1a_pkg::LED_CMD;
            o_res.last  = 1'b0;
        end else if (char_c != 8'h00) begin
            o_res.count = scs1a_pkg::CNT_ONE;
        end
    end

endmodule

`default_nettype wire

// File: rtl/scancode_set1_to_ascii_unit.sv
// ----------------------------------------------------------------------------
// scancode_set1_to_ascii_unit
// Set-1 keyboard scancode to character translator with modifier and lock
// tracking and keyboard LED command generation.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one raw scancode byte per
//   item. Output channel (o_out_valid / i_out_stall) carries result items:
//   kind, value and last. Break codes and modifier keys give no result;
//   ordinary keys give at most one character; Caps, Num and Scroll lock give
//   two LED command bytes (0xED, then the new lock mask, last on the mask).
//   Path: a scancode accepted into the input register is decoded
//   combinationally and its first result is loaded into the result register.
//   Throughput: one scancode per cycle while the receiver does not stall; a lock
//   key holds the next scancode in the input register while the mask byte
//   follows the command byte. The single result register sets this rate.
//   Reset (i_rst_n low, synchronous) clears held modifiers, lock flags and
//   all valid flags; o_in_stall is high while reset is asserted.
//   When the receiver stalls, the result register holds its item and the
//   input register can still take one more scancode before o_in_stall rises.
// ----------------------------------------------------------------------------
`default_nettype none

module scancode_set1_to_ascii_unit (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    // scancode input channel
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic [7:0] i_in_scancode,
    // result output channel
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic            o_out_kind,
    output logic [7:0]      o_out_value,
    output logic            o_out_last
);

`include "scancode_set1_to_ascii_unit_assert.svh"

    // registers
    logic       r_in_valid, n_in_valid;
    logic [7:0] r_in_code,  n_in_code;
    logic       r_out_valid, n_out_valid;
    logic       r_out_kind,  n_out_kind;
    logic [7:0] r_out_value, n_out_value;
    logic       r_out_last,  n_out_last;
    logic       r_pend,      n_pend;
    logic [2:0] r_pend_mask, n_pend_mask;
    logic [2:0] r_mods,      n_mods;
    logic [2:0] r_locks,     n_locks;

    logic                 out_free;
    logic                 proc;
    logic                 in_acc;
    scs1a_pkg::t_xlat_res xres;

    // decode of the held scancode
    scs1a_xlat u_xlat (
        .i_scancode (r_in_code),
        .i_mods     (r_mods),
        .i_locks    (r_locks),
        .o_res      (xres)
    );

    // handshake control
    assign out_free   = ~r_out_valid | ~i_out_stall;
    assign proc       = r_in_valid & out_free & ~r_pend;
    assign o_in_stall = ~i_rst_n | (r_in_valid & ~proc);
    assign in_acc     = i_in_valid & ~o_in_stall;

    // next-state logic
    always_comb begin
        n_in_valid  = in_acc | (r_in_valid & ~proc);
        n_in_code   = in_acc ? i_in_scancode : r_in_code;
        n_out_valid = r_out_valid;
        n_out_kind  = r_out_kind;
        n_out_value = r_out_value;
        n_out_last  = r_out_last;
        n_pend      = r_pend;
        n_pend_mask = r_pend_mask;
        n_mods      = r_mods;
        n_locks     = r_locks;
        if (out_free) begin
            n_out_valid = 1'b0;
            if (r_pend) begin
                // second LED byte: the lock mask
                n_out_valid = 1'b1;
                n_out_kind  = scs1a_pkg::KIND_LED;
                n_out_value = {5'b00000, r_pend_mask};
                n_out_last  = 1'b1;
                n_pend      = 1'b0;
            end else if (proc && xres.count != scs1a_pkg::CNT_NONE) begin
                n_out_valid = 1'b1;
                n_out_kind  = xres.kind;
                n_out_value = xres.value;
                n_out_last  = xres.last;
                n_pend      = xres.count == scs1a_pkg::CNT_TWO;
                n_pend_mask = xres.locks;
            end
        end
        if (proc) begin
            n_mods  = xres.mods;
            n_locks = xres.locks;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_pend      <= 1'b0;
            r_mods      <= 3'b000;
            r_locks     <= 3'b000;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
            r_pend      <= n_pend;
            r_mods      <= n_mods;
            r_locks     <= n_locks;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_in_code   <= n_in_code;
        r_out_kind  <= n_out_kind;
        r_out_value <= n_out_value;
        r_out_last  <= n_out_last;
        r_pend_mask <= n_pend_mask;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_kind  = r_out_kind;
    assign o_out_value = r_out_value;
    assign o_out_last  = r_out_last;

    // checks
    `SCS1A_ASSERT_IMPL(a_pend_led, i_clk, i_rst_n, r_pend, r_out_valid && r_out_kind == scs1a_pkg::KIND_LED && !r_out_last)
    `SCS1A_ASSERT_NEXT(a_led_mask, i_clk, i_rst_n, r_out_valid && r_out_kind == scs1a_pkg::KIND_LED && !r_out_last && !i_out_stall, r_out_valid && r_out_kind == scs1a_pkg::KIND_LED && r_out_last)
    `SCS1A_ASSERT_IMPL(a_char_ok, i_clk, i_rst_n, r_out_valid && r_out_kind == scs1a_pkg::KIND_CHAR, r_out_last && r_out_value != 8'h00)

endmodule

`default_nettype wire

// File: verif/scancode_set1_to_ascii_unit_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Scancode translator checker
// Watches both channels of the set-1 scancode translator. Each accepted
// scancode is run through a local translator that tracks held modifiers and
// lock flags; the bytes it produces are queued and every accepted result
// item is compared field by field with the oldest queued byte.
// ----------------------------------------------------------------------------
module scancode_set1_to_ascii_unit_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_stall,
    input  logic [7:0] i_in_scancode,
    input  logic       i_out_valid,
    input  logic       i_out_stall,
    input  logic       i_out_kind,
    input  logic [7:0] i_out_value,
    input  logic       i_out_last,
    output int         o_fail_count,
    output int         o_pending
);

    localparam int TABLE_SIZE  = 89;

    // character bounds used by the case and control rules
    localparam logic [7:0] LOWER_A    = 8'h61;
    localparam logic [7:0] LOWER_Z    = 8'h7A;
    localparam logic [7:0] UPPER_A    = 8'h41;
    localparam logic [7:0] UPPER_Z    = 8'h5A;
    localparam logic [7:0] LBRACKET   = 8'h5B;
    localparam logic [7:0] UNDERSCORE = 8'h5F;
    localparam logic [7:0] CTRL_SHIFT = 8'h60;

    // unshifted key map, indexed by make code
    localparam logic [7:0] PLAIN_MAP [0:TABLE_SIZE-1] = '{
        8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
        8'h37, 8'h38, 8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09,
        8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
        8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h00, 8'h61, 8'h73,
        8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
        8'h27, 8'h60, 8'h00, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76,
        8'h62, 8'h6E, 8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h00,
        8'h00, 8'h20, 8'h00, 8'h80, 8'h81, 8'h82, 8'h83, 8'h84,
        8'h85, 8'h86, 8'h87, 8'h88, 8'h89, 8'h00, 8'h00, 8'h92,
        8'h97, 8'h94, 8'h2D, 8'h96, 8'h35, 8'h99, 8'h2B, 8'h93,
        8'h98, 8'h95, 8'h90, 8'h91, 8'h00, 8'h00, 8'h00, 8'h8A,
        8'h8B
    };

    // shifted key map
    localparam logic [7:0] SHIFTED_KEYS [0:TABLE_SIZE-1] = '{
        8'h00, 8'h1B, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E,
        8'h26, 8'h2A, 8'h28, 8'h29, 8'h5F, 8'h2B, 8'h08, 8'h09,
        8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
        8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0A, 8'h00, 8'h41, 8'h53,
        8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3A,
        8'h22, 8'h7E, 8'h00, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56,
        8'h42, 8'h4E, 8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h00, 8'h00,
        8'h00, 8'h20, 8'h00, 8'h80, 8'h81, 8'h82, 8'h83, 8'h84,
        8'h85, 8'h86, 8'h87, 8'h88, 8'h89, 8'h00, 8'h00, 8'h92,
        8'h97, 8'h94, 8'h2D, 8'h96, 8'h35, 8'h99, 8'h2B, 8'h93,
        8'h98, 8'h95, 8'h90, 8'h91, 8'h00, 8'h00, 8'h00, 8'h8A,
        8'h8B
    };

    typedef struct packed {
        logic       kind;
        logic [7:0] value;
        logic       last;
    } t_key_byte;

    t_key_byte  predicted_bytes [$];
    logic [2:0] held_mods;
    logic [2:0] lock_state;
    int         mismatches = 0;

    // log one mismatch
    task automatic note_mismatch(input string field, input int exp_val, input int act_val);
        $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h",
                 $time, field, exp_val, act_val);
        mismatches++;
    endtask

    // translate one scancode, update modifier/lock tracking, queue its bytes
    task automatic decode_scancode(input logic [7:0] raw);
        logic [6:0] code;
        logic [7:0] p;
        logic [7:0] s;
        logic [7:0] ch;
        code = raw[6:0];
        ch   = 8'h00;
        if (raw[7]) begin
            // break: release a modifier, nothing emitted
            if (code == scs1a_pkg::KEY_ALT) held_mods[scs1a_pkg::MOD_ALT] = 1'b0;
            if (code == scs1a_pkg::KEY_CTRL) held_mods[scs1a_pkg::MOD_CTRL] = 1'b0;
            if (code == scs1a_pkg::KEY_LSHIFT || code == scs1a_pkg::KEY_RSHIFT)
                held_mods[scs1a_pkg::MOD_SHIFT] = 1'b0;
        end else if (code == scs1a_pkg::KEY_ALT) begin
            held_mods[scs1a_pkg::MOD_ALT] = 1'b1;
        end else if (code == scs1a_pkg::KEY_CTRL) begin
            held_mods[scs1a_pkg::MOD_CTRL] = 1'b1;
        end else if (code == scs1a_pkg::KEY_LSHIFT || code == scs1a_pkg::KEY_RSHIFT) begin
            held_mods[scs1a_pkg::MOD_SHIFT] = 1'b1;
        end else if (code == scs1a_pkg::KEY_CAPS || code == scs1a_pkg::KEY_NUM ||
                     code == scs1a_pkg::KEY_SCROLL) begin
            // lock toggle, then LED command pair
            if (code == scs1a_pkg::KEY_CAPS)
                lock_state[scs1a_pkg::LOCK_CAPS] = ~lock_state[scs1a_pkg::LOCK_CAPS];
            if (code == scs1a_pkg::KEY_NUM)
                lock_state[scs1a_pkg::LOCK_NUM] = ~lock_state[scs1a_pkg::LOCK_NUM];
            if (code == scs1a_pkg::KEY_SCROLL)
                lock_state[scs1a_pkg::LOCK_SCRL] = ~lock_state[scs1a_pkg::LOCK_SCRL];
            predicted_bytes.push_back('{kind: scs1a_pkg::KIND_LED,
                                        value: scs1a_pkg::LED_CMD, last: 1'b0});
            predicted_bytes.push_back('{kind: scs1a_pkg::KIND_LED,
                                        value: {5'd0, lock_state}, last: 1'b1});
        end else begin
            if (held_mods[scs1a_pkg::MOD_ALT]) begin
                ch = {1'b0, code};
            end else if (int'(code) < TABLE_SIZE) begin
                p = PLAIN_MAP[code];
                s = SHIFTED_KEYS[code];
                if (held_mods[scs1a_pkg::MOD_CTRL]) begin
                    if (p >= LOWER_A && p <= LOWER_Z) ch = p - CTRL_SHIFT;
                    else if (p >= LBRACKET && p <= UNDERSCORE)
                        ch = p - LBRACKET + scs1a_pkg::CTRL_BASE;
                end else if (held_mods[scs1a_pkg::MOD_SHIFT]) begin
                    ch = (lock_state[scs1a_pkg::LOCK_CAPS] && s >= UPPER_A && s <= UPPER_Z)
                         ? p : s;
                end else begin
                    ch = (lock_state[scs1a_pkg::LOCK_CAPS] && p >= LOWER_A && p <= LOWER_Z)
                         ? s : p;
                end
            end
            if (ch != 8'h00) begin
                predicted_bytes.push_back('{kind: scs1a_pkg::KIND_CHAR, value: ch,
                                            last: 1'b1});
            end
        end
    endtask

    // sample both channels at the rising edge
    always @(posedge i_clk) begin
        t_key_byte want;
        if (!i_rst_n) begin
            held_mods  = 3'b000;
            lock_state = 3'b000;
            predicted_bytes.delete();
        end else begin
            // results are checked before the same-edge scancode is decoded
            if (i_out_valid && !i_out_stall) begin
                if (predicted_bytes.size() == 0) begin
                    $display("%0t: unexpected result, expected none, %s %0d %0h %0d",
                             $time, "got kind/value/last", i_out_kind, i_out_value,
                             i_out_last);
                    mismatches++;
                end else begin
                    want = predicted_bytes.pop_front();
                    if (i_out_kind !== want.kind) note_mismatch("kind", want.kind, i_out_kind);
                    if (i_out_value !== want.value)
                        note_mismatch("value", want.value, i_out_value);
                    if (i_out_last !== want.last) note_mismatch("last", want.last, i_out_last);
                end
            end
            if (i_in_valid && !i_in_stall) decode_scancode(i_in_scancode);
        end
        o_pending    <= predicted_bytes.size();
        o_fail_count <= mismatches;
    end

endmodule

// File: verif/scancode_set1_to_ascii_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Scancode translator testbench
// Drives scancodes into the set-1 translator: a directed walk through the
// modifier, lock, control and table paths, then random keyboard traffic in
// three idle/stall phases. A checker beside the block predicts and compares
// results; this module reports the verdict.
// ----------------------------------------------------------------------------
module scancode_set1_to_ascii_unit_test;

    localparam int PHASE_ITEMS = 670;
    localparam int QUIET_LIMIT = 1000;
    localparam int DRAIN_WAIT  = 20;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_stall;
    logic [7:0] i_in_scancode;
    logic       o_out_valid;
    logic       i_out_stall;
    logic       o_out_kind;
    logic [7:0] o_out_value;
    logic       o_out_last;

    int fail_count;
    int pending;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int quiet_cycles   = 0;

    scancode_set1_to_ascii_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_in_scancode (i_in_scancode),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_kind    (o_out_kind),
        .o_out_value   (o_out_value),
        .o_out_last    (o_out_last)
    );

    scancode_set1_to_ascii_unit_checker i_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_stall    (o_in_stall),
        .i_in_scancode (i_in_scancode),
        .i_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .i_out_kind    (o_out_kind),
        .i_out_value   (o_out_value),
        .i_out_last    (o_out_last),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    // clock
    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    // receiver stall, redrawn every cycle
    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // watchdog: cycles with no item moving on either channel
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("TB_ERROR");
        $finish;
    end

    // present one scancode and hold it until accepted
    task automatic send_scancode(input logic [7:0] code);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_in_scancode <= code;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // drop valid and hold off until every predicted byte has come out
    task automatic drain_results();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    // keyboard-like traffic: mostly make codes, modifier and lock keys,
    // with break codes and arbitrary bytes mixed in
    function automatic logic [7:0] random_scancode();
        int         sel;
        logic [6:0] key;
        sel = $urandom_range(99);
        if (sel < 20) begin
            case ($urandom_range(3))
                0: key = scs1a_pkg::KEY_ALT;
                1: key = scs1a_pkg::KEY_CTRL;
                2: key = scs1a_pkg::KEY_LSHIFT;
                default: key = scs1a_pkg::KEY_RSHIFT;
            endcase
            return {($urandom_range(99) < 65), key};
        end else if (sel < 25) begin
            case ($urandom_range(2))
                0: key = scs1a_pkg::KEY_CAPS;
                1: key = scs1a_pkg::KEY_NUM;
                default: key = scs1a_pkg::KEY_SCROLL;
            endcase
            return {1'b0, key};
        end else if (sel < 80) begin
            return {1'b0, 7'($urandom_range(88))};
        end else if (sel < 90) begin
            return {1'b1, 7'($urandom)};
        end
        return 8'($urandom);
    endfunction

    initial begin
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_in_scancode = 8'h00;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: table edges, each modifier and lock, caps with shift,
        // control letters and brackets, alt raw codes, stray break codes
        send_scancode(8'h00);
        send_scancode(8'h7F);
        send_scancode(8'h1E);
        send_scancode({1'b0, scs1a_pkg::KEY_CAPS});
        send_scancode(8'h1E);
        send_scancode({1'b0, scs1a_pkg::KEY_LSHIFT});
        send_scancode(8'h1E);
        send_scancode(8'h02);
        send_scancode({1'b1, scs1a_pkg::KEY_LSHIFT});
        send_scancode({1'b0, scs1a_pkg::KEY_CAPS});
        send_scancode({1'b0, scs1a_pkg::KEY_CTRL});
        send_scancode(8'h1E);
        send_scancode(8'h1A);
        send_scancode(8'h2B);
        send_scancode(8'h02);
        send_scancode({1'b1, scs1a_pkg::KEY_CTRL});
        send_scancode({1'b0, scs1a_pkg::KEY_ALT});
        send_scancode(8'h7F);
        send_scancode(8'h00);
        send_scancode({1'b0, scs1a_pkg::KEY_NUM});
        send_scancode({1'b1, scs1a_pkg::KEY_ALT});
        send_scancode({1'b0, scs1a_pkg::KEY_SCROLL});
        send_scancode(8'h3B);
        send_scancode(8'hFF);
        send_scancode(8'h80);

        // random traffic under three idle/stall mixes
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct  = 32;
                    recv_stall_pct = 67;
                end
                1: begin
                    send_idle_pct  = 67;
                    recv_stall_pct = 32;
                end
                default: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (phase == 1 && n == PHASE_ITEMS / 2) drain_results();
                send_scancode(random_scancode());
            end
        end

        // wait out the remaining results, then a short settle
        drain_results();
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
